[sv/lcip_pkg.sv]
// shared types, constants and codes of the layered cell image parser
package lcip_pkg;

  // fixed field widths of the result and configuration ports
  localparam int unsigned CoordW      = 24;
  localparam int unsigned LayerW      = 7;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ColorW      = 24;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned CfgIdxW     = 1;

  // default for the dimension bound parameter of the top level
  localparam int unsigned CoordWidthDefault = 24;

  // reset values of the configuration registers
  localparam logic [LayerW-1:0] LayerLimitRst = 7'd64;
  localparam logic [CoordW-1:0] CellLimitRst  = 24'd10000000;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgLayerLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCellLimit  = 1'd1;

  // result queue geometry, depth is a power of two
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // parser phases
  typedef enum logic [2:0] {
    PH_FILE    = 3'd0,
    PH_LAYER   = 3'd1,
    PH_CELL    = 3'd2,
    PH_DONE    = 3'd3,
    PH_DISCARD = 3'd4
  } phase_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_FILE_HDR  = 3'd0,
    KIND_LAYER_HDR = 3'd1,
    KIND_CELL      = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_COMPLETE  = 3'd4
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_TRUNCATED  = 2'd0,
    ERR_LAYERS     = 2'd1,
    ERR_DIMENSIONS = 2'd2,
    ERR_TRAILING   = 2'd3
  } err_e;

  // one result item
  typedef struct packed {
    logic [2:0]              result_kind;
    logic [LayerW-1:0]       layer_num;
    logic [CoordW-1:0]       column_x;
    logic [CoordW-1:0]       row_y;
    logic [CoordW-1:0]       cell_address;
    logic [WordW-1:0]        glyph;
    logic [ColorW-1:0]       foreground;
    logic [ColorW-1:0]       background;
    logic signed [WordW-1:0] format_version;
    logic [CoordW-1:0]       layer_width;
    logic [CoordW-1:0]       layer_height;
    logic [1:0]              error_code;
  } result_t;

endpackage

[sv/lcip_parser.sv]
// byte parser: header, layer and cell decoding with up to two results per byte
module lcip_parser #(
  parameter int unsigned COORD_WIDTH = lcip_pkg::CoordWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          eos_i,
  input  logic [lcip_pkg::LayerW-1:0]   layer_limit_i,
  input  logic [lcip_pkg::CoordW-1:0]   cell_limit_i,
  output logic [1:0]                    n_res_o,
  output lcip_pkg::result_t             res0_o,
  output lcip_pkg::result_t             res1_o
);
  import lcip_pkg::*;

  localparam logic [63:0] CoordMax = (64'd1 << COORD_WIDTH) - 64'd1;
  localparam logic [3:0]  CellLastPos = 4'd9;

  phase_e              phase_q, phase_d;
  logic [3:0]          pos_q, pos_d;
  logic [WordW-1:0]    word_q, word_d;
  logic [WordW-1:0]    ver_q, ver_d;
  logic [WordW-1:0]    glyph_q, glyph_d;
  logic [47:0]         color_q, color_d;
  logic [LayerW-1:0]   ldecl_q, ldecl_d;
  logic [LayerW-1:0]   layer_q, layer_d;
  logic [CoordW-1:0]   width_q, width_d;
  logic [CoordW-1:0]   height_q, height_d;
  logic [CoordW-1:0]   col_q, col_d;
  logic [CoordW-1:0]   row_q, row_d;
  logic [CoordW-1:0]   addr_q, addr_d;

  logic [3:0]          pos_inc;
  logic [WordW-1:0]    word_sh;
  logic [47:0]         color_sh;
  logic [47:0]         prod;
  logic                dims_bad;
  logic [CoordW-1:0]   row_nx;
  logic [CoordW-1:0]   col_nx;
  logic [LayerW-1:0]   layer_nx;
  logic                main_v, tail_v;
  result_t             main_r, tail_r;

  assign pos_inc  = pos_q + 4'd1;
  assign word_sh  = {data_byte_i, word_q[WordW-1:8]};
  assign color_sh = {color_q[39:0], data_byte_i};
  assign row_nx   = row_q + 24'd1;
  assign col_nx   = col_q + 24'd1;
  assign layer_nx = layer_q + 7'd1;

  // width word sits in glyph_q while the height word completes
  assign prod = glyph_q[CoordW-1:0] * word_sh[CoordW-1:0];

  always_comb begin
    dims_bad = 1'b0;
    if ((glyph_q == '0) || (word_sh == '0)) begin
      dims_bad = 1'b1;
    end else if ((glyph_q[WordW-1:CoordW] != '0) || (word_sh[WordW-1:CoordW] != '0)) begin
      // product then exceeds any 24-bit cell limit
      dims_bad = 1'b1;
    end else if (prod > {24'd0, cell_limit_i}) begin
      dims_bad = 1'b1;
    end else if ({16'd0, prod} > CoordMax) begin
      dims_bad = 1'b1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    word_d   = word_q;
    ver_d    = ver_q;
    glyph_d  = glyph_q;
    color_d  = color_q;
    ldecl_d  = ldecl_q;
    layer_d  = layer_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    addr_d   = addr_q;
    main_v   = 1'b0;
    main_r   = '0;
    tail_v   = 1'b0;
    tail_r   = '0;
    if (valid_i) begin
      case (phase_q)
        PH_FILE: begin
          pos_d  = pos_inc;
          word_d = word_sh;
          if (pos_inc == 4'd4) begin
            ver_d = word_sh;
          end else if (pos_inc == 4'd8) begin
            pos_d  = '0;
            main_v = 1'b1;
            if (word_sh > {25'd0, layer_limit_i}) begin
              main_r.result_kind = KIND_ERROR;
              main_r.layer_num   = layer_q;
              main_r.error_code  = ERR_LAYERS;
              phase_d            = PH_DISCARD;
            end else begin
              ldecl_d               = word_sh[LayerW-1:0];
              layer_d               = '0;
              main_r.result_kind    = KIND_FILE_HDR;
              main_r.layer_num      = word_sh[LayerW-1:0];
              main_r.format_version = ver_q;
              phase_d = (word_sh[LayerW-1:0] != '0) ? PH_LAYER : PH_DONE;
            end
          end
        end
        PH_LAYER: begin
          pos_d  = pos_inc;
          word_d = word_sh;
          if (pos_inc == 4'd4) begin
            glyph_d = word_sh;
          end else if (pos_inc == 4'd8) begin
            pos_d  = '0;
            main_v = 1'b1;
            main_r.layer_num = layer_q;
            if (dims_bad) begin
              main_r.result_kind = KIND_ERROR;
              main_r.error_code  = ERR_DIMENSIONS;
              phase_d            = PH_DISCARD;
            end else begin
              width_d             = glyph_q[CoordW-1:0];
              height_d            = word_sh[CoordW-1:0];
              col_d               = '0;
              row_d               = '0;
              addr_d              = '0;
              main_r.result_kind  = KIND_LAYER_HDR;
              main_r.layer_width  = glyph_q[CoordW-1:0];
              main_r.layer_height = word_sh[CoordW-1:0];
              phase_d             = PH_CELL;
            end
          end
        end
        PH_CELL: begin
          pos_d = pos_inc;
          if (pos_q < 4'd4) begin
            word_d = word_sh;
            if (pos_inc == 4'd4) begin
              glyph_d = word_sh;
            end
          end else begin
            color_d = color_sh;
          end
          if (pos_q == CellLastPos) begin
            pos_d               = '0;
            main_v              = 1'b1;
            main_r.result_kind  = KIND_CELL;
            main_r.layer_num    = layer_q;
            main_r.column_x     = col_q;
            main_r.row_y        = row_q;
            main_r.cell_address = addr_q;
            main_r.glyph        = glyph_q;
            main_r.foreground   = color_sh[47:24];
            main_r.background   = color_sh[23:0];
            row_d               = row_nx;
            addr_d              = addr_q + width_q;
            if (row_nx >= height_q) begin
              // column finished, address restarts at the top of the next column
              row_d  = '0;
              col_d  = col_nx;
              addr_d = col_nx;
              if (col_nx >= width_q) begin
                layer_d = layer_nx;
                phase_d = (layer_nx >= ldecl_q) ? PH_DONE : PH_LAYER;
              end
            end
          end
        end
        PH_DONE: begin
          main_v             = 1'b1;
          main_r.result_kind = KIND_ERROR;
          main_r.layer_num   = layer_q;
          main_r.error_code  = ERR_TRAILING;
          phase_d            = PH_DISCARD;
        end
        default: begin
        end
      endcase

      if (eos_i) begin
        if (phase_d == PH_DONE) begin
          tail_v             = 1'b1;
          tail_r.result_kind = KIND_COMPLETE;
          tail_r.layer_num   = ldecl_d;
        end else if (phase_d != PH_DISCARD) begin
          tail_v             = 1'b1;
          tail_r.result_kind = KIND_ERROR;
          tail_r.layer_num   = layer_d;
          tail_r.error_code  = ERR_TRUNCATED;
        end
        // final byte always rearms for the next file
        phase_d  = PH_FILE;
        pos_d    = '0;
        word_d   = '0;
        ver_d    = '0;
        glyph_d  = '0;
        color_d  = '0;
        ldecl_d  = '0;
        layer_d  = '0;
        width_d  = '0;
        height_d = '0;
        col_d    = '0;
        row_d    = '0;
        addr_d   = '0;
      end
    end
  end

  always_comb begin
    n_res_o = {1'b0, main_v} + {1'b0, tail_v};
    res0_o  = main_v ? main_r : tail_r;
    res1_o  = tail_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FILE;
      pos_q    <= '0;
      word_q   <= '0;
      ver_q    <= '0;
      glyph_q  <= '0;
      color_q  <= '0;
      ldecl_q  <= '0;
      layer_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      addr_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      word_q   <= word_d;
      ver_q    <= ver_d;
      glyph_q  <= glyph_d;
      color_q  <= color_d;
      ldecl_q  <= ldecl_d;
      layer_q  <= layer_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      addr_q   <= addr_d;
    end
  end

  a_two_only_on_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res_o == 2'd2) |-> (valid_i && eos_i))
    else $error("two results from a byte that is not final");

  a_eos_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && eos_i) |=> (phase_q == PH_FILE && pos_q == 4'd0))
    else $error("parser not rearmed after final byte");

  a_cell_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CELL) |-> (pos_q <= CellLastPos))
    else $error("cell byte position out of range");

endmodule

[sv/lcip_fifo.sv]
// small result queue that takes up to two results per cycle
module lcip_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_n_i,
  input  lcip_pkg::result_t             d0_i,
  input  lcip_pkg::result_t             d1_i,
  input  logic                          pop_i,
  output logic [lcip_pkg::FifoCntW-1:0] count_o,
  output logic                          valid_o,
  output lcip_pkg::result_t             q_o
);
  import lcip_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoPtrW-1:0]   wr_ptr_nx;
  logic                  do_pop;

  assign do_pop    = pop_i && (cnt_q != '0);
  assign wr_ptr_nx = wr_ptr_q + FifoPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_n_i);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(do_pop);
    cnt_d    = cnt_q + FifoCntW'(push_n_i) - FifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= d0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign count_o = cnt_q;
  assign valid_o = (cnt_q != '0);
  assign q_o     = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) + 32'(push_n_i)) <= FifoDepth)
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FifoPtrW'(wr_ptr_q - rd_ptr_q) == FifoPtrW'(cnt_q)))
    else $error("queue pointers disagree with count");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && push_n_i == 2'd0) |=> (cnt_q == '0))
    else $error("queue count moved without a push");

endmodule

[sv/layered_cell_image_parser.sv]
// top level of the layered cell image parser: input stage, config, parser, result queue
//
// input channel: one byte of the decompressed file per transfer on
// in_valid_i/in_ready_o, with end_of_stream_i set on the last byte
// output channel: one result per transfer on out_valid_o/out_ready_i,
// result_kind_o tells which of the other fields carry meaning
// config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 layer limit, 1 cell limit); the user must write only while idle, the block does not enforce it
// path: an accepted byte is registered in the input stage and parsed in the next cycle;
// its results are then registered in the result queue, which offers them
// throughput: one byte per cycle while in_ready_o is high; a byte gives at most
// two results and only the final byte gives two
// the four-entry result queue decouples the sides: in_ready_o stays high
// while at most two results are queued or pending, so a stalled receiver
// throttles the input only once results back up
// reset: layer limit 64, cell limit 10,000,000, parser waits for a file
// header, queue empty, no transfer offered
module layered_cell_image_parser #(
  parameter int unsigned COORD_WIDTH = lcip_pkg::CoordWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            end_of_stream_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      result_kind_o,
  output logic [lcip_pkg::LayerW-1:0]     layer_num_o,
  output logic [lcip_pkg::CoordW-1:0]     column_x_o,
  output logic [lcip_pkg::CoordW-1:0]     row_y_o,
  output logic [lcip_pkg::CoordW-1:0]     cell_address_o,
  output logic [lcip_pkg::WordW-1:0]      glyph_o,
  output logic [lcip_pkg::ColorW-1:0]     foreground_o,
  output logic [lcip_pkg::ColorW-1:0]     background_o,
  output logic signed [lcip_pkg::WordW-1:0] format_version_o,
  output logic [lcip_pkg::CoordW-1:0]     layer_width_o,
  output logic [lcip_pkg::CoordW-1:0]     layer_height_o,
  output logic [1:0]                      error_code_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [lcip_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lcip_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import lcip_pkg::*;

  // input stage
  logic                 stage_v_q;
  logic [7:0]           stage_byte_q;
  logic                 stage_eos_q;
  logic                 in_xfer;

  // configuration registers
  logic [LayerW-1:0]    layer_limit_q, layer_limit_d;
  logic [CoordW-1:0]    cell_limit_q, cell_limit_d;

  // parser to queue
  logic [1:0]           n_res;
  result_t              res0, res1;
  logic [FifoCntW-1:0]  fifo_cnt;
  logic [FifoCntW:0]    committed;
  result_t              out_r;

  assign in_xfer = in_valid_i && in_ready_o;

  // results already queued plus those the staged byte is about to push;
  // a new byte may add two more
  assign committed  = {1'b0, fifo_cnt} + (FifoCntW+1)'(n_res);
  assign in_ready_o = (32'(committed) <= (FifoDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= in_xfer;
    end
  end

  // payload of the stage needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_byte_q <= data_byte_i;
      stage_eos_q  <= end_of_stream_i;
    end
  end

  always_comb begin
    layer_limit_d = layer_limit_q;
    cell_limit_d  = cell_limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLayerLimit: layer_limit_d = cfg_wdata_i[LayerW-1:0];
        CfgCellLimit:  cell_limit_d  = cfg_wdata_i[CoordW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_limit_q <= LayerLimitRst;
      cell_limit_q  <= CellLimitRst;
    end else begin
      layer_limit_q <= layer_limit_d;
      cell_limit_q  <= cell_limit_d;
    end
  end

  lcip_parser #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (stage_v_q),
    .data_byte_i   (stage_byte_q),
    .eos_i         (stage_eos_q),
    .layer_limit_i (layer_limit_q),
    .cell_limit_i  (cell_limit_q),
    .n_res_o       (n_res),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  lcip_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (n_res),
    .d0_i     (res0),
    .d1_i     (res1),
    .pop_i    (out_ready_i),
    .count_o  (fifo_cnt),
    .valid_o  (out_valid_o),
    .q_o      (out_r)
  );

  // unpack the queued result onto the field ports
  assign result_kind_o    = out_r.result_kind;
  assign layer_num_o      = out_r.layer_num;
  assign column_x_o       = out_r.column_x;
  assign row_y_o          = out_r.row_y;
  assign cell_address_o   = out_r.cell_address;
  assign glyph_o          = out_r.glyph;
  assign foreground_o     = out_r.foreground;
  assign background_o     = out_r.background;
  assign format_version_o = out_r.format_version;
  assign layer_width_o    = out_r.layer_width;
  assign layer_height_o   = out_r.layer_height;
  assign error_code_o     = out_r.error_code;

  a_stage_follows_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> stage_v_q)
    else $error("accepted byte did not reach the parser");

  a_room_for_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_v_q |-> (32'(committed) <= FifoDepth))
    else $error("staged byte has no room in the result queue");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_v_q |-> (n_res == 2'd0))
    else $error("results pushed without a staged byte");

endmodule

[bench/tb_top.sv]
// self-checking bench for the layered cell image parser: directed fields, random files, limits
module tb_top;
  import lcip_pkg::*;

  // largest dimension product the block can address
  localparam logic [63:0] CoordMax = (64'd1 << CoordWidthDefault) - 64'd1;
  // cycles without any transfer before the run is called hung
  localparam int unsigned StallLimit = 3000;
  // receiver hold-off that backs up the result queue and stalls the input
  localparam int unsigned LongHold = 200;

  // one byte offered on the input channel, plus an optional typed expectation
  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    kind_e      kind;
    logic [6:0] layer;
    err_e       code;
  } stim_t;

  // one directed row: a little-endian field of 1 to 4 bytes
  typedef struct {
    int unsigned nbytes;
    logic [31:0] value;
    logic        eos;
    logic        typed;
    kind_e       kind;
    logic [6:0]  layer;
    err_e        code;
  } field_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = 8'd0;
  logic end_of_stream_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] result_kind_o;
  logic [LayerW-1:0] layer_num_o;
  logic [CoordW-1:0] column_x_o, row_y_o, cell_address_o;
  logic [WordW-1:0] glyph_o;
  logic [ColorW-1:0] foreground_o, background_o;
  logic signed [WordW-1:0] format_version_o;
  logic [CoordW-1:0] layer_width_o, layer_height_o;
  logic [1:0] error_code_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgLayerLimit;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  layered_cell_image_parser dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .data_byte_i, .end_of_stream_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .layer_num_o,
    .column_x_o, .row_y_o, .cell_address_o, .glyph_o, .foreground_o, .background_o,
    .format_version_o, .layer_width_o, .layer_height_o, .error_code_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bench copy of the limit registers, updated on every write
  logic [6:0]  layer_cap;
  logic [23:0] cell_cap;

  // parser state as the bench sees it
  phase_e      prs_phase;
  logic [3:0]  prs_pos;
  logic [31:0] word_acc, ver_hold, glyph_hold;
  logic [47:0] color_acc;
  logic [6:0]  layers_decl, layer_cur;
  logic [23:0] width_cur, height_cur, col_cnt, row_cnt, addr_cnt;

  result_t pending_results[$];  // results still owed by the block, oldest first
  result_t byte_results[$];     // results caused by the byte being parsed
  stim_t   file_bytes[$];       // file under construction
  stim_t   cur_item;            // sideband of the byte currently offered
  field_row_t directed_rows[25];

  int unsigned mismatches = 0;
  logic hold_request = 1'b0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  function automatic result_t blank_result(input kind_e kind, input logic [6:0] layer);
    result_t r;
    r = '0;
    r.result_kind = kind;
    r.layer_num = layer;
    return r;
  endfunction

  task automatic clear_parser();
    prs_phase = PH_FILE;
    prs_pos = '0;
    word_acc = '0;
    ver_hold = '0;
    glyph_hold = '0;
    color_acc = '0;
    layers_decl = '0;
    layer_cur = '0;
    width_cur = '0;
    height_cur = '0;
    col_cnt = '0;
    row_cnt = '0;
    addr_cnt = '0;
  endtask

  task automatic shift_in(input logic [7:0] b);
    word_acc = {b, word_acc[31:8]};
    prs_pos = prs_pos + 4'd1;
  endtask

  task automatic flag_error(input err_e code);
    result_t r;
    r = blank_result(KIND_ERROR, layer_cur);
    r.error_code = code;
    byte_results.insert(byte_results.size(), r);
    prs_phase = PH_DISCARD;
  endtask

  // advances the bench parser by one byte, appending what it causes to byte_results
  task automatic parse_byte(input logic [7:0] b, input logic eos);
    result_t r;
    logic [63:0] area;
    case (prs_phase)
      PH_FILE: begin
        shift_in(b);
        if (prs_pos == 4'd4) begin
          ver_hold = word_acc;
        end else if (prs_pos == 4'd8) begin
          prs_pos = '0;
          if (word_acc > {25'd0, layer_cap}) begin
            flag_error(ERR_LAYERS);
          end else begin
            layers_decl = word_acc[6:0];
            layer_cur = '0;
            r = blank_result(KIND_FILE_HDR, layers_decl);
            r.format_version = ver_hold;
            byte_results.insert(byte_results.size(), r);
            prs_phase = (layers_decl != 7'd0) ? PH_LAYER : PH_DONE;
          end
        end
      end
      PH_LAYER: begin
        shift_in(b);
        if (prs_pos == 4'd4) begin
          // raw width waits in the glyph holder while the height comes in
          glyph_hold = word_acc;
        end else if (prs_pos == 4'd8) begin
          prs_pos = '0;
          area = {32'd0, glyph_hold} * {32'd0, word_acc};
          if (glyph_hold == 32'd0 || word_acc == 32'd0 || area > {40'd0, cell_cap} ||
              area > CoordMax) begin
            flag_error(ERR_DIMENSIONS);
          end else begin
            width_cur = glyph_hold[23:0];
            height_cur = word_acc[23:0];
            col_cnt = '0;
            row_cnt = '0;
            addr_cnt = '0;
            r = blank_result(KIND_LAYER_HDR, layer_cur);
            r.layer_width = width_cur;
            r.layer_height = height_cur;
            byte_results.insert(byte_results.size(), r);
            prs_phase = PH_CELL;
          end
        end
      end
      PH_CELL: begin
        if (prs_pos < 4'd4) begin
          shift_in(b);
          if (prs_pos == 4'd4) glyph_hold = word_acc;
        end else begin
          color_acc = {color_acc[39:0], b};
          prs_pos = prs_pos + 4'd1;
        end
        if (prs_pos >= 4'd10) begin
          prs_pos = '0;
          r = blank_result(KIND_CELL, layer_cur);
          r.column_x = col_cnt;
          r.row_y = row_cnt;
          r.cell_address = addr_cnt;
          r.glyph = glyph_hold;
          r.foreground = color_acc[47:24];
          r.background = color_acc[23:0];
          byte_results.insert(byte_results.size(), r);
          // cells come column by column, the address is row-major
          row_cnt = row_cnt + 24'd1;
          addr_cnt = addr_cnt + width_cur;
          if (row_cnt >= height_cur) begin
            row_cnt = '0;
            col_cnt = col_cnt + 24'd1;
            addr_cnt = col_cnt;
            if (col_cnt >= width_cur) begin
              layer_cur = layer_cur + 7'd1;
              prs_phase = (layer_cur >= layers_decl) ? PH_DONE : PH_LAYER;
            end
          end
        end
      end
      PH_DONE: flag_error(ERR_TRAILING);
      default: begin
      end
    endcase
    // last byte of a file: complete, truncated, or silent after an error
    if (eos) begin
      if (prs_phase == PH_DONE) begin
        byte_results.insert(byte_results.size(), blank_result(KIND_COMPLETE, layers_decl));
      end else if (prs_phase != PH_DISCARD) begin
        flag_error(ERR_TRUNCATED);
      end
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // input transfers feed the bench parser, output transfers are checked in order
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t typed_res;
    if (rst_ni && in_valid_i && in_ready_o) begin
      byte_results.delete();
      parse_byte(data_byte_i, end_of_stream_i);
      if (cur_item.typed) begin
        // directed rows with a result known by inspection
        typed_res = blank_result(cur_item.kind, cur_item.layer);
        typed_res.error_code = cur_item.code;
        pending_results.insert(pending_results.size(), typed_res);
      end else begin
        foreach (byte_results[i]) pending_results.insert(pending_results.size(), byte_results[i]);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result kind expected none actual %0d", $time, result_kind_o);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_kind_o));
        check_field("layer_num", 32'(want.layer_num), 32'(layer_num_o));
        check_field("column_x", 32'(want.column_x), 32'(column_x_o));
        check_field("row_y", 32'(want.row_y), 32'(row_y_o));
        check_field("cell_address", 32'(want.cell_address), 32'(cell_address_o));
        check_field("glyph", want.glyph, glyph_o);
        check_field("foreground", 32'(want.foreground), 32'(foreground_o));
        check_field("background", 32'(want.background), 32'(background_o));
        check_field("format_version", want.format_version, format_version_o);
        check_field("layer_width", 32'(want.layer_width), 32'(layer_width_o));
        check_field("layer_height", 32'(want.layer_height), 32'(layer_height_o));
        check_field("error_code", 32'(want.error_code), 32'(error_code_o));
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
    end
  end

  // no transfer on either side for too long means the block hung
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_top: errors");
    $finish;
  end

  // offers one byte after an optional gap and returns at the edge of its transfer
  task automatic send_byte(input stim_t s);
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 99) < 35) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= s.data;
    end_of_stream_i <= s.eos;
    cur_item <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender pause: every owed result in, then the pipeline given time to settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // both limit registers, written back to back while the block is idle
  task automatic write_limits(input logic [23:0] layer_value, input logic [23:0] cell_value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgLayerLimit;
    cfg_wdata_i <= layer_value;
    @(posedge clk_i);
    layer_cap = layer_value[6:0];
    cfg_idx_i <= CfgCellLimit;
    cfg_wdata_i <= cell_value;
    @(posedge clk_i);
    cell_cap = cell_value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_bytes(input logic [31:0] value, input int unsigned count);
    stim_t s;
    s = '{8'd0, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED};
    for (int unsigned k = 0; k < count; k++) begin
      s.data = value[8*k +: 8];
      file_bytes.insert(file_bytes.size(), s);
    end
  endtask

  // one random file: mostly well formed, the rest broken in one way or another
  task automatic build_file();
    int unsigned mode, n_layers, w, h, cut, span;
    file_bytes.delete();
    mode = $urandom_range(0, 99);
    add_bytes($urandom, 4);
    if (mode < 64) begin
      n_layers = ($urandom_range(0, 9) == 0) ? 0 :
                 $urandom_range(1, (layer_cap < 3) ? layer_cap : 3);
      add_bytes(n_layers, 4);
      for (int unsigned l = 0; l < n_layers; l++) begin
        w = $urandom_range(1, (cell_cap < 3) ? cell_cap : 3);
        span = cell_cap / w;
        h = $urandom_range(1, (span < 3) ? span : 3);
        add_bytes(w, 4);
        add_bytes(h, 4);
        for (int unsigned c = 0; c < w * h; c++) begin
          add_bytes($urandom, 4);
          add_bytes($urandom, 3);
          add_bytes($urandom, 3);
        end
      end
      case ($urandom_range(0, 9))
        0: begin
          // cut short anywhere
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        1: add_bytes($urandom, $urandom_range(1, 3));
        default: begin
        end
      endcase
    end else if (mode < 72) begin
      case ($urandom_range(0, 2))
        0: add_bytes(layer_cap + 1, 4);
        1: add_bytes($urandom_range(layer_cap + 1, 127), 4);
        default: add_bytes($urandom | 32'h8000_0000, 4);
      endcase
      add_bytes($urandom, $urandom_range(0, 4));
    end else if (mode < 84) begin
      add_bytes($urandom_range(1, (layer_cap < 3) ? layer_cap : 3), 4);
      case ($urandom_range(0, 3))
        0: begin
          add_bytes(0, 4);
          add_bytes($urandom, 4);
        end
        1: begin
          add_bytes($urandom_range(1, 5), 4);
          add_bytes(0, 4);
        end
        2: begin
          // one to three above the cell limit, or above what the coordinates can hold
          add_bytes(cell_cap + $urandom_range(1, 3), 4);
          add_bytes(1, 4);
        end
        default: begin
          add_bytes($urandom | 32'h1, 4);
          add_bytes($urandom | 32'h0100_0000, 4);
        end
      endcase
      add_bytes($urandom, $urandom_range(0, 3));
    end else if (mode < 92) begin
      // largest or random accepted layer count, largest area, then cut off inside the cells
      add_bytes($urandom_range(0, 1) ? layer_cap : $urandom_range(1, layer_cap), 4);
      if ($urandom_range(0, 1)) begin
        add_bytes(32'(cell_cap), 4);
        add_bytes(1, 4);
      end else begin
        add_bytes(1, 4);
        add_bytes(32'(cell_cap), 4);
      end
      for (int unsigned k = $urandom_range(0, 15); k > 0; k--) add_bytes($urandom, 1);
    end else begin
      file_bytes.delete();
      for (int unsigned k = $urandom_range(1, 12); k > 0; k--) add_bytes($urandom, 1);
    end
    file_bytes[file_bytes.size() - 1].eos = 1'b1;
  endtask

  // random files until the byte budget of this setting is spent
  task automatic run_random(input int unsigned budget, input logic long_hold);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_file();
      tx_steady = ($urandom_range(0, 3) == 0);
      foreach (file_bytes[i]) begin
        send_byte(file_bytes[i]);
        sent++;
        if (long_hold && sent == 60) hold_request = 1'b1;
      end
    end
    drain_results();
  endtask

  initial begin : stimulus
    stim_t s;
    layer_cap = LayerLimitRst;
    cell_cap = CellLimitRst;
    clear_parser();
    cur_item = '{8'd0, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED};
    // fields of short files at the reset limits; typed rows carry their expected error
    directed_rows = '{
      // zero layers, most negative version, final byte completes the file
      '{4, 32'h8000_0000, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'h0000_0000, 1'b1, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      // too many layers, then discarded bytes up to a silent final byte
      '{4, 32'h7FFF_FFFF, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd65, 1'b0, 1'b1, KIND_ERROR, 7'd0, ERR_LAYERS},
      '{1, 32'hFF, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{1, 32'h00, 1'b1, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      // zero width
      '{4, 32'd1, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd1, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd0, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd5, 1'b0, 1'b1, KIND_ERROR, 7'd0, ERR_DIMENSIONS},
      '{1, 32'h33, 1'b1, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      // one 1x1 layer with extreme cell content, completed on the last color byte
      '{4, 32'd3, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd1, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd1, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd1, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{3, 32'h00FF_FFFF, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{3, 32'h0000_0000, 1'b1, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      // trailing byte after an empty file
      '{4, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'd0, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{1, 32'h5A, 1'b0, 1'b1, KIND_ERROR, 7'd0, ERR_TRAILING},
      '{1, 32'hA5, 1'b1, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      // stream ends inside the version word
      '{2, 32'h1234, 1'b1, 1'b1, KIND_ERROR, 7'd0, ERR_TRUNCATED},
      // error on the final byte stands alone
      '{4, 32'd0, 1'b0, 1'b0, KIND_FILE_HDR, 7'd0, ERR_TRUNCATED},
      '{4, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_ERROR, 7'd0, ERR_LAYERS}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int unsigned k = 0; k < directed_rows[r].nbytes; k++) begin
        s.data = directed_rows[r].value[8*k +: 8];
        s.eos = directed_rows[r].eos && (k == directed_rows[r].nbytes - 1);
        s.typed = directed_rows[r].typed && (k == directed_rows[r].nbytes - 1);
        s.kind = directed_rows[r].kind;
        s.layer = directed_rows[r].layer;
        s.code = directed_rows[r].code;
        send_byte(s);
      end
    end
    drain_results();

    // tightest limits
    write_limits(24'd1, 24'd1);
    run_random(180, 1'b0);
    // widest cell limit and reset layer limit, with the long receiver hold
    write_limits(24'd64, 24'hFF_FFFF);
    run_random(280, 1'b1);
    // random small limits
    write_limits(24'($urandom_range(1, 64)), 24'($urandom_range(2, 12)));
    run_random(190, 1'b0);
    // layer limit with junk above its width, random cell limit
    write_limits(24'hFF_FF80 | 24'($urandom_range(1, 63)), 24'($urandom_range(1, 24'hFF_FFFF)));
    run_random(190, 1'b0);

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
